/* sv/swipe_pkg.sv */
// Shared types and constants for the swipe gesture classifier.
// No dependencies; used by every module of the block.
package swipe_pkg;

    localparam int COORD_BITS = 11;
    localparam int TIME_BITS  = 32;

    localparam int MIN_DIST_W = 12;
    localparam int MAX_TIME_W = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int DIR_W      = 3;
    localparam int DIST_W     = 12;
    localparam int DUR_W      = 16;

    // squared distance and root datapath widths
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int ACC_W      = SQ_W + 1;
    localparam int ROOT_STEPS = (SQ_W + 1) / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

    localparam logic [DIST_W-1:0]     DIST_MAX         = '1;
    localparam logic [MIN_DIST_W-1:0] MIN_DISTANCE_RST = MIN_DIST_W'(50);
    localparam logic [MAX_TIME_W-1:0] MAX_TIME_RST     = MAX_TIME_W'(1000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME     = 1'b1;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_TAP   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd4;

    typedef struct packed {
        logic capture;
        logic load_origin;
        logic load_diff;
        logic load_sq;
        logic load_sum;
        logic root_step;
        logic load_out;
    } swipe_cmd_t;

    typedef struct packed {
        logic pressed;
        logic elapsed_ok;
    } swipe_status_t;

endpackage

/* sv/swipe_dp.sv */
// Datapath: sample and origin registers, config registers, squares,
// iterative square root and result register. Depends on swipe_pkg.
module swipe_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swipe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swipe_pkg::CFG_W-1:0]         cfg_data,
    input  logic [swipe_pkg::COORD_BITS-1:0]    pos_x,
    input  logic [swipe_pkg::COORD_BITS-1:0]    pos_y,
    input  logic                                pressed,
    input  logic [swipe_pkg::TIME_BITS-1:0]     stamp_ms,
    input  swipe_pkg::swipe_cmd_t               cmd,
    output swipe_pkg::swipe_status_t            status,
    output logic [swipe_pkg::DIR_W-1:0]         direction,
    output logic [swipe_pkg::DIST_W-1:0]        distance,
    output logic [swipe_pkg::DUR_W-1:0]         duration
);

    localparam int CW = swipe_pkg::COORD_BITS;
    localparam int TW = swipe_pkg::TIME_BITS;
    localparam int AW = swipe_pkg::ACC_W;

    logic [swipe_pkg::MIN_DIST_W-1:0] min_distance_reg;
    logic [swipe_pkg::MAX_TIME_W-1:0] max_time_reg;

    logic [CW-1:0] smp_x_reg, smp_y_reg;
    logic          smp_pressed_reg;
    logic [TW-1:0] smp_stamp_reg;
    logic [CW-1:0] origin_x_reg, origin_y_reg;
    logic [TW-1:0] origin_time_reg;

    logic [CW-1:0]                  adx_reg, ady_reg;
    logic                           x_pos_reg, y_pos_reg;
    logic [swipe_pkg::DUR_W-1:0]    dur_reg;
    logic [2*CW-1:0]                sqx_reg, sqy_reg;
    logic [AW-1:0]                  rem_reg, root_reg, bit_reg;

    logic [swipe_pkg::DIR_W-1:0]    direction_reg;
    logic [swipe_pkg::DIST_W-1:0]   distance_reg;
    logic [swipe_pkg::DUR_W-1:0]    duration_reg;

    logic [TW-1:0] elapsed;
    logic          x_pos, y_pos;
    logic [CW-1:0] adx, ady;
    logic [AW-1:0] trial;
    logic          tap;
    logic [swipe_pkg::DIST_W-1:0] dist_sat;
    logic [swipe_pkg::DIR_W-1:0]  dir_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= swipe_pkg::MIN_DISTANCE_RST;
            max_time_reg     <= swipe_pkg::MAX_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swipe_pkg::REG_MIN_DISTANCE:
                    min_distance_reg <= cfg_data[swipe_pkg::MIN_DIST_W-1:0];
                swipe_pkg::REG_MAX_TIME:
                    max_time_reg <= cfg_data[swipe_pkg::MAX_TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // release against origin
    assign elapsed = smp_stamp_reg - origin_time_reg;
    assign x_pos   = smp_x_reg > origin_x_reg;
    assign y_pos   = smp_y_reg > origin_y_reg;
    assign adx     = x_pos ? smp_x_reg - origin_x_reg : origin_x_reg - smp_x_reg;
    assign ady     = y_pos ? smp_y_reg - origin_y_reg : origin_y_reg - smp_y_reg;

    assign status.pressed    = smp_pressed_reg;
    assign status.elapsed_ok = elapsed <= TW'(max_time_reg);

    // one root digit per step
    assign trial = root_reg + bit_reg;

    // classification of the finished root
    assign tap      = root_reg < AW'(min_distance_reg);
    assign dist_sat = (root_reg > AW'(swipe_pkg::DIST_MAX)) ? swipe_pkg::DIST_MAX
                                                           : root_reg[swipe_pkg::DIST_W-1:0];

    always_comb
    begin
        priority if (tap)
            dir_next = swipe_pkg::DIR_TAP;
        else if (adx_reg > ady_reg)
            dir_next = x_pos_reg ? swipe_pkg::DIR_RIGHT : swipe_pkg::DIR_LEFT;
        else
            dir_next = y_pos_reg ? swipe_pkg::DIR_DOWN : swipe_pkg::DIR_UP;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_x_reg       <= pos_x;
            smp_y_reg       <= pos_y;
            smp_pressed_reg <= pressed;
            smp_stamp_reg   <= stamp_ms;
        end
        if (cmd.load_origin)
        begin
            origin_x_reg    <= smp_x_reg;
            origin_y_reg    <= smp_y_reg;
            origin_time_reg <= smp_stamp_reg;
        end
        if (cmd.load_diff)
        begin
            adx_reg   <= adx;
            ady_reg   <= ady;
            x_pos_reg <= x_pos;
            y_pos_reg <= y_pos;
            dur_reg   <= elapsed[swipe_pkg::DUR_W-1:0];
        end
        if (cmd.load_sq)
        begin
            sqx_reg <= (2*CW)'(adx_reg) * (2*CW)'(adx_reg);
            sqy_reg <= (2*CW)'(ady_reg) * (2*CW)'(ady_reg);
        end
        if (cmd.load_sum)
        begin
            rem_reg  <= AW'(sqx_reg) + AW'(sqy_reg);
            root_reg <= '0;
            bit_reg  <= AW'(1) << (2 * (swipe_pkg::ROOT_STEPS - 1));
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.load_out)
        begin
            direction_reg <= dir_next;
            distance_reg  <= dist_sat;
            duration_reg  <= dur_reg;
        end
    end

    assign direction = direction_reg;
    assign distance  = distance_reg;
    assign duration  = duration_reg;

endmodule

/* sv/swipe_ctrl.sv */
// Controller: state machine, touch-active flag, root step counter and
// result valid flag. Depends on swipe_pkg.
module swipe_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  swipe_pkg::swipe_status_t  status,
    output swipe_pkg::swipe_cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_SQR  = 6'b000100,
        S_SUM  = 6'b001000,
        S_ROOT = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    localparam int CNT_W = swipe_pkg::ROOT_CNT_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(swipe_pkg::ROOT_STEPS - 1);

    state_t           state_reg, state_next;
    logic             active_reg, active_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] step_cnt_reg, step_cnt_next;

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        step_cnt_next  = step_cnt_reg;
        cmd            = '0;
        cmd.capture    = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.load_diff = 1'b1;
                state_next    = S_IDLE;
                if (status.pressed)
                begin
                    if (!active_reg)
                    begin
                        cmd.load_origin = 1'b1;
                        active_next     = 1'b1;
                    end
                end
                else if (active_reg)
                begin
                    active_next = 1'b0;
                    if (status.elapsed_ok)
                        state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                cmd.load_sq = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.load_sum  = 1'b1;
                step_cnt_next = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_cnt_next = step_cnt_reg + CNT_W'(1);
                if (step_cnt_reg == CNT_LAST)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the result slot to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            step_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            step_cnt_reg  <= step_cnt_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // root iteration starts from a cleared counter
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |=> (state_reg == S_ROOT && step_cnt_reg == '0))
        else $error("root iteration not started cleanly");

    // last root step hands over to output
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT && step_cnt_reg == CNT_LAST) |=> state_reg == S_OUT)
        else $error("root iteration count wrong");

    // a release always ends the touch
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && !status.pressed) |=> !active_reg)
        else $error("touch still active after release");
`endif

endmodule

/* sv/swipe_gesture_classifier_top.sv */
// A release request, once accepted, passes EVAL, SQR, SUM, ROOT and OUT before out_valid rises.
// Press and ignored requests pass IDLE and EVAL only; a release that yields a gesture also runs
//   the 12-step restoring square root (one digit a cycle). No new request is taken until IDLE.
// A finished gesture waits in the output register while the next request is taken.
// Reset (rst_n, async, active low): no touch active, no result pending, registers
//   min_distance = 50 and max_time = 1000.
// Top level of the swipe gesture classifier; instantiates swipe_ctrl and swipe_dp.
// Depends on swipe_pkg.
module swipe_gesture_classifier_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [swipe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swipe_pkg::CFG_W-1:0]       cfg_data,
    // touch sample request
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swipe_pkg::COORD_BITS-1:0]  pos_x,
    input  logic [swipe_pkg::COORD_BITS-1:0]  pos_y,
    input  logic                              pressed,
    input  logic [swipe_pkg::TIME_BITS-1:0]   stamp_ms,
    // gesture request
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swipe_pkg::DIR_W-1:0]       direction,
    output logic [swipe_pkg::DIST_W-1:0]      distance,
    output logic [swipe_pkg::DUR_W-1:0]       duration
);

    // Flow per request:
    //   IDLE  - take the sample into the datapath
    //   EVAL  - press while idle stores origin; release while active ends the touch
    //           and, if the elapsed time fits max_time, starts the gesture math
    //   SQR   - square |dx| and |dy|
    //   SUM   - add the squares, seed the root
    //   ROOT  - one result bit per cycle
    //   OUT   - classify and load the output register once it is free

    swipe_pkg::swipe_cmd_t    cmd;
    swipe_pkg::swipe_status_t status;

    swipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    swipe_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pressed   (pressed),
        .stamp_ms  (stamp_ms),
        .cmd       (cmd),
        .status    (status),
        .direction (direction),
        .distance  (distance),
        .duration  (duration)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for swipe_gesture_classifier_top: touch samples in, gestures out.
// A behavioral predictor builds expected gestures that the output monitor checks in order.
// Depends on swipe_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 7;
    // cycles to let a request that yields no gesture finish before a register write
    localparam int          SETTLE_CYCLES = 24;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          COORD_MAX     = (1 << swipe_pkg::COORD_BITS) - 1;

    typedef struct packed {
        logic [swipe_pkg::COORD_BITS-1:0] x;
        logic [swipe_pkg::COORD_BITS-1:0] y;
        logic                             down;
        logic [swipe_pkg::TIME_BITS-1:0]  stamp;
    } touch_sample_t;

    typedef struct packed {
        logic [swipe_pkg::DIR_W-1:0]  dir;
        logic [swipe_pkg::DIST_W-1:0] dist_px;
        logic [swipe_pkg::DUR_W-1:0]  dur;
    } gesture_t;

    // DUT inputs start known; the driver, monitor and test sequence own them after time zero
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [swipe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [swipe_pkg::CFG_W-1:0]      cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic [swipe_pkg::COORD_BITS-1:0] pos_x     = '0;
    logic [swipe_pkg::COORD_BITS-1:0] pos_y     = '0;
    logic                             pressed   = 1'b0;
    logic [swipe_pkg::TIME_BITS-1:0]  stamp_ms  = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [swipe_pkg::DIR_W-1:0]      direction;
    logic [swipe_pkg::DIST_W-1:0]     distance;
    logic [swipe_pkg::DUR_W-1:0]      duration;

    touch_sample_t pending_samples[$];
    gesture_t      expected_gestures[$];

    // predictor copy of the block's state and registers
    logic                             touch_on;
    logic [swipe_pkg::COORD_BITS-1:0] start_x;
    logic [swipe_pkg::COORD_BITS-1:0] start_y;
    logic [swipe_pkg::TIME_BITS-1:0]  start_stamp;
    int unsigned                      cfg_min_dist;
    int unsigned                      cfg_max_time;

    // generator side view of whether a touch is open, for sequence shaping
    bit                    gen_touch_on;
    int                    gen_items;

    bit                    tx_steady;
    bit                    rx_steady;
    int                    fail_count;
    int unsigned           cycle_count;

    swipe_gesture_classifier_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pressed   (pressed),
        .stamp_ms  (stamp_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .direction (direction),
        .distance  (distance),
        .duration  (duration)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // floor square root, one result bit per pass from the top down
    function automatic logic [swipe_pkg::DIST_W-1:0] floor_root(int unsigned v);
        logic [swipe_pkg::DIST_W-1:0] r;
        int unsigned                  trial;
        r = '0;
        for (int b = swipe_pkg::DIST_W - 1; b >= 0; b--)
        begin
            trial = int'(r) | (1 << b);
            if (trial * trial <= v)
                r = swipe_pkg::DIST_W'(trial);
        end
        return r;
    endfunction

    // Apply one accepted request to the predictor; queue a gesture if one results.
    function automatic void classify_sample(touch_sample_t s);
        logic [swipe_pkg::TIME_BITS-1:0] elapsed;
        int                              dx;
        int                              dy;
        int unsigned                     adx;
        int unsigned                     ady;
        gesture_t                        g;
        if (s.down)
        begin
            // a press while a touch is open keeps the original origin
            if (!touch_on)
            begin
                start_x     = s.x;
                start_y     = s.y;
                start_stamp = s.stamp;
                touch_on    = 1'b1;
            end
            return;
        end
        if (!touch_on)
            return;
        touch_on = 1'b0;
        // modular difference: a wrap of the ms counter is harmless
        elapsed = s.stamp - start_stamp;
        if (elapsed > swipe_pkg::TIME_BITS'(cfg_max_time))
            return;
        dx  = int'(s.x) - int'(start_x);
        dy  = int'(s.y) - int'(start_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        g.dist_px = floor_root(adx * adx + ady * ady);
        g.dur     = swipe_pkg::DUR_W'(elapsed);
        if (g.dist_px < cfg_min_dist)
            g.dir = swipe_pkg::DIR_TAP;
        else if (adx > ady)
            g.dir = (dx > 0) ? swipe_pkg::DIR_RIGHT : swipe_pkg::DIR_LEFT;
        else
            g.dir = (dy > 0) ? swipe_pkg::DIR_DOWN : swipe_pkg::DIR_UP;  // a tie is vertical
        expected_gestures.insert(expected_gestures.size(), g);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // Driver: one touch request on the bus at a time, from pending_samples
    // ---------------------------------------------------------------
    touch_sample_t cur_sample;
    int            tx_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                classify_sample(cur_sample);
            // bus is free for a new request after this edge
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    cur_sample = pending_samples.pop_front();
                    pos_x    <= cur_sample.x;
                    pos_y    <= cur_sample.y;
                    pressed  <= cur_sample.down;
                    stamp_ms <= cur_sample.stamp;
                    in_valid <= 1'b1;
                    tx_gap   = tx_steady ? 0 : pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, in-order check against the predictor
    // ---------------------------------------------------------------
    int rx_stall;

    always @(posedge clk or negedge rst_n)
    begin
        gesture_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_gestures.size() == 0)
                begin
                    $error("gesture with none predicted: direction %0d distance %0d duration %0d",
                           direction, distance, duration);
                    fail_count++;
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (direction !== want.dir)
                    begin
                        $error("direction mismatch: expected %0d, actual %0d",
                               want.dir, direction);
                        fail_count++;
                    end
                    if (distance !== want.dist_px)
                    begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               want.dist_px, distance);
                        fail_count++;
                    end
                    if (duration !== want.dur)
                    begin
                        $error("duration mismatch: expected %0d, actual %0d",
                               want.dur, duration);
                        fail_count++;
                    end
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 25)
                    rx_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Queue one touch request and count it.
    task automatic add_sample(int x, int y, bit down, logic [swipe_pkg::TIME_BITS-1:0] stamp);
        touch_sample_t s;
        s.x     = swipe_pkg::COORD_BITS'(x);
        s.y     = swipe_pkg::COORD_BITS'(y);
        s.down  = down;
        s.stamp = stamp;
        pending_samples.insert(pending_samples.size(), s);
        gen_items++;
        gen_touch_on = down;
    endtask

    function automatic int nudge(int base, int delta);
        int v;
        v = base + delta;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    // Wait until nothing is in flight, then let a silent release finish.
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_gestures.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [swipe_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= swipe_pkg::CFG_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == swipe_pkg::REG_MIN_DISTANCE)
            cfg_min_dist = val;
        else
            cfg_max_time = val;
        @(negedge clk);
    endtask

    // Mostly well-formed press / drag / release sequences with random content,
    // plus stray requests and presses on an open touch.
    task automatic random_gestures(int target);
        int          stop_at;
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        int          d;
        int          span;
        int          r;
        int unsigned elapsed;
        logic [swipe_pkg::TIME_BITS-1:0] t0;
        stop_at = gen_items + target;
        while (gen_items < stop_at)
        begin
            tx_steady = ($urandom_range(0, 5) == 0);
            rx_steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 99) < 8)
            begin
                // stray request: may be ignored, may open or close a touch
                add_sample($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, 1), $urandom);
                continue;
            end
            if (gen_touch_on)
                add_sample($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           1'b0, $urandom);
            x0 = $urandom_range(0, COORD_MAX);
            y0 = $urandom_range(0, COORD_MAX);
            t0 = $urandom;
            add_sample(x0, y0, 1'b1, t0);
            // drag samples while down leave the origin alone
            repeat ($urandom_range(0, 2))
                add_sample($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           1'b1, $urandom);
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                span = ($urandom_range(0, 3) == 0) ? cfg_min_dist + 20 : 80;
                x1 = nudge(x0, $urandom_range(0, 2 * span) - span);
                y1 = nudge(y0, $urandom_range(0, 2 * span) - span);
            end
            else if (r < 60)
            begin
                // equal |dx| and |dy| where the edges allow it
                d  = $urandom_range(0, 700);
                x1 = $urandom_range(0, 1) ? x0 + d : x0 - d;
                y1 = $urandom_range(0, 1) ? y0 + d : y0 - d;
                if (x1 < 0 || x1 > COORD_MAX || y1 < 0 || y1 > COORD_MAX)
                begin
                    x1 = nudge(x1, 0);
                    y1 = nudge(y1, 0);
                end
            end
            else
            begin
                x1 = $urandom_range(0, COORD_MAX);
                y1 = $urandom_range(0, COORD_MAX);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                elapsed = $urandom_range(0, cfg_max_time);
            else if (r < 80)
                elapsed = cfg_max_time;
            else if (r < 95)
                elapsed = cfg_max_time + 1 + $urandom_range(0, 200);
            else
                elapsed = $urandom;
            add_sample(x1, y1, 1'b0, t0 + elapsed);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        touch_on     = 1'b0;
        start_x      = '0;
        start_y      = '0;
        start_stamp  = '0;
        cfg_min_dist = swipe_pkg::MIN_DISTANCE_RST;
        cfg_max_time = swipe_pkg::MAX_TIME_RST;
        gen_touch_on = 1'b0;
        gen_items    = 0;
        fail_count   = 0;
        cycle_count  = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: min_distance 50, max_time 1000
        add_sample(5, 5, 1'b0, 100);                         // release with no touch open
        add_sample(0, 0, 1'b1, 0);                           // full diagonal at max_time, tie
        add_sample(COORD_MAX, COORD_MAX, 1'b0, 1000);
        add_sample(COORD_MAX, COORD_MAX, 1'b1, 32'hFFFF_FFF0);
        add_sample(0, 0, 1'b1, 32'h0000_0005);               // press on open touch
        add_sample(0, 0, 1'b0, 32'h0000_0010);               // ms counter wraps, up
        add_sample(1000, 500, 1'b1, 2000);
        add_sample(1600, 500, 1'b0, 2100);                   // right
        add_sample(1600, 700, 1'b1, 3000);
        add_sample(100, 750, 1'b0, 3999);                    // left
        add_sample(500, 500, 1'b1, 4000);
        add_sample(510, 520, 1'b0, 4010);                    // tap
        add_sample(800, 800, 1'b1, 5000);
        add_sample(800, 800, 1'b0, 6001);                    // one ms too long
        add_sample(300, 1200, 1'b1, 7000);
        add_sample(310, 200, 1'b0, 7050);                    // up
        add_sample(300, 200, 1'b1, 8000);
        add_sample(290, 1500, 1'b0, 8050);                   // down
        add_sample(0, 0, 1'b1, 9000);
        add_sample(30, 40, 1'b0, 9010);                      // exactly min_distance
        add_sample(1000, 1000, 1'b1, 9100);
        add_sample(1049, 1000, 1'b0, 9110);                  // just under min_distance
        add_sample(0, COORD_MAX, 1'b1, 32'hFFFF_FFFF);
        add_sample(COORD_MAX, 0, 1'b0, 32'h0000_03E7);       // wrap, tie with dy negative
        wait_for_quiet();

        // Lower extremes: no movement with min_distance 0 comes out as up
        write_reg(swipe_pkg::REG_MIN_DISTANCE, 0);
        write_reg(swipe_pkg::REG_MAX_TIME, 0);
        add_sample(1234, 567, 1'b1, 32'h8000_0000);
        add_sample(1234, 567, 1'b0, 32'h8000_0000);
        add_sample(0, 0, 1'b1, 77);
        add_sample(COORD_MAX, 0, 1'b0, 77);
        add_sample(5, 5, 1'b1, 300);
        add_sample(6, 5, 1'b0, 301);                         // over a zero limit
        random_gestures(120);
        wait_for_quiet();

        // Upper extremes: every release is a tap, longest duration passes
        write_reg(swipe_pkg::REG_MIN_DISTANCE, 2895);
        write_reg(swipe_pkg::REG_MAX_TIME, 65535);
        add_sample(0, 0, 1'b1, 10);
        add_sample(COORD_MAX, COORD_MAX, 1'b0, 10 + 65535);
        add_sample(9, 9, 1'b1, 100);
        add_sample(9, 9, 1'b0, 100 + 65536);
        random_gestures(120);
        wait_for_quiet();

        // Random settings
        repeat (3)
        begin
            write_reg(swipe_pkg::REG_MIN_DISTANCE,
                      $urandom_range(0, 1) ? $urandom_range(0, 150) : $urandom_range(0, 2895));
            write_reg(swipe_pkg::REG_MAX_TIME,
                      $urandom_range(0, 1) ? $urandom_range(50, 3000)
                                           : $urandom_range(0, 65535));
            random_gestures(100);
            // sender holds off until every gesture so far has come back
            wait_for_quiet();
            random_gestures(100);
            wait_for_quiet();
        end

        // Back to the reset values, written explicitly
        write_reg(swipe_pkg::REG_MIN_DISTANCE, swipe_pkg::MIN_DISTANCE_RST);
        write_reg(swipe_pkg::REG_MAX_TIME, swipe_pkg::MAX_TIME_RST);
        random_gestures(100);
        wait_for_quiet();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
